[rtl/pcrq_pkg.sv]
// pcrq_pkg: shared types and constants of the per-client request queue
// used by pcrq_ctrl, pcrq_dpath and the per_client_request_queue_core top level
// no dependencies

package pcrq_pkg;

   // fixed port widths
   localparam int MODE_W      = 3;
   localparam int CLIENT_W    = 6;
   localparam int ID_W        = 63;
   localparam int SIZE_PORT_W = 16;
   localparam int QCOUNT_W    = 7;
   localparam int QBYTES_W    = 22;
   localparam int TOTAL_W     = 32;

   // request modes
   localparam logic [MODE_W-1:0] MODE_PROBE        = 3'd0;
   localparam logic [MODE_W-1:0] MODE_APPEND       = 3'd1;
   localparam logic [MODE_W-1:0] MODE_APPEND_EMPTY = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP          = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REMOVE       = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLEAR        = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_LINK,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic eval;
      logic link;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_link;
      logic out_free;
   } sts_type;

endpackage

[rtl/per_client_request_queue_core.sv]
// Per-client request queue: a FIFO holding at most one pending request per
// client, kept as a doubly linked list through per-client slots held in three
// single-port-write memories (id and size, next pointer, previous pointer) with
// slot valid bits in flip-flops, so reset and clear take effect at once and no
// clearing pass is needed. One request is worked on at a time. A probe, pop,
// remove, clear or refused append goes through slot read, evaluate and unlink,
// and result; an accepted append adds a link step before the result that links
// the new entry behind the tail, since the next-pointer memory has one write
// port. A new request is accepted in the cycle after the result is loaded, even
// while that result still waits on rsp_ready; a result that finds the result
// register still full waits for it.
// depends on pcrq_pkg, pcrq_ctrl, pcrq_dpath and pcrq_ram

module per_client_request_queue_core #(
   parameter int NUM_CLIENTS = 64,
   parameter int SIZE_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pcrq_pkg::MODE_W-1:0]         req_mode,
   input  logic [pcrq_pkg::CLIENT_W-1:0]       req_client,
   input  logic [pcrq_pkg::ID_W-1:0]           req_request_id,
   input  logic [pcrq_pkg::SIZE_PORT_W-1:0]    req_request_size,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_ok,
   output logic                                rsp_removed_any,
   output logic [pcrq_pkg::CLIENT_W-1:0]       rsp_out_client,
   output logic [pcrq_pkg::ID_W-1:0]           rsp_out_request_id,
   output logic [pcrq_pkg::SIZE_PORT_W-1:0]    rsp_out_size,
   output logic [pcrq_pkg::QCOUNT_W-1:0]       rsp_queue_count,
   output logic [pcrq_pkg::QBYTES_W-1:0]       rsp_queue_bytes,
   output logic [pcrq_pkg::TOTAL_W-1:0]        rsp_total_added,
   output logic [pcrq_pkg::TOTAL_W-1:0]        rsp_total_removed
);

   pcrq_pkg::cmd_type cmd;
   pcrq_pkg::sts_type sts;

   pcrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pcrq_dpath #(
      .NUM_CLIENTS (NUM_CLIENTS),
      .SIZE_BITS   (SIZE_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_mode           (req_mode),
      .req_client         (req_client),
      .req_request_id     (req_request_id),
      .req_request_size   (req_request_size),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_ok             (rsp_ok),
      .rsp_removed_any    (rsp_removed_any),
      .rsp_out_client     (rsp_out_client),
      .rsp_out_request_id (rsp_out_request_id),
      .rsp_out_size       (rsp_out_size),
      .rsp_queue_count    (rsp_queue_count),
      .rsp_queue_bytes    (rsp_queue_bytes),
      .rsp_total_added    (rsp_total_added),
      .rsp_total_removed  (rsp_total_removed)
   );

endmodule

[rtl/pcrq_ram.sv]
// pcrq_ram: generic single write port, single read port ram with registered read
// no dependencies

module pcrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/pcrq_ctrl.sv]
// pcrq_ctrl: sequencing state machine of the per-client request queue
// depends on pcrq_pkg

module pcrq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pcrq_pkg::sts_type sts,
   output pcrq_pkg::cmd_type cmd
);

   pcrq_pkg::state_type state_ff;
   pcrq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcrq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         pcrq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = pcrq_pkg::ST_EVAL;
            end
         end
         pcrq_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.need_link ? pcrq_pkg::ST_LINK : pcrq_pkg::ST_RESP;
         end
         pcrq_pkg::ST_LINK: begin
            cmd.link = 1'b1;
            state_in = pcrq_pkg::ST_RESP;
         end
         pcrq_pkg::ST_RESP: begin
            // wait until the result register can take the outcome
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = pcrq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pcrq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/pcrq_dpath.sv]
// pcrq_dpath: slot memories, linked-list pointers, counters and result register
// depends on pcrq_pkg and pcrq_ram

module pcrq_dpath #(
   parameter int NUM_CLIENTS = 64,
   parameter int SIZE_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pcrq_pkg::cmd_type                   cmd,
   output pcrq_pkg::sts_type                   sts,
   input  logic [pcrq_pkg::MODE_W-1:0]         req_mode,
   input  logic [pcrq_pkg::CLIENT_W-1:0]       req_client,
   input  logic [pcrq_pkg::ID_W-1:0]           req_request_id,
   input  logic [pcrq_pkg::SIZE_PORT_W-1:0]    req_request_size,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_ok,
   output logic                                rsp_removed_any,
   output logic [pcrq_pkg::CLIENT_W-1:0]       rsp_out_client,
   output logic [pcrq_pkg::ID_W-1:0]           rsp_out_request_id,
   output logic [pcrq_pkg::SIZE_PORT_W-1:0]    rsp_out_size,
   output logic [pcrq_pkg::QCOUNT_W-1:0]       rsp_queue_count,
   output logic [pcrq_pkg::QBYTES_W-1:0]       rsp_queue_bytes,
   output logic [pcrq_pkg::TOTAL_W-1:0]        rsp_total_added,
   output logic [pcrq_pkg::TOTAL_W-1:0]        rsp_total_removed
);

   localparam int IDX_W  = $clog2(NUM_CLIENTS);
   localparam int SLOT_W = $clog2(NUM_CLIENTS + 1);
   localparam int CNT_W  = $clog2(NUM_CLIENTS + 1);
   localparam int SZ_W   = (SIZE_BITS < pcrq_pkg::SIZE_PORT_W) ? SIZE_BITS
                                                                : pcrq_pkg::SIZE_PORT_W;
   localparam int DATA_W = pcrq_pkg::ID_W + SZ_W;
   localparam logic [SLOT_W-1:0] NONE_SLOT = SLOT_W'(NUM_CLIENTS);

   // request registers
   logic [pcrq_pkg::MODE_W-1:0] mode_ff;
   logic                        cok_ff;
   logic [IDX_W-1:0]            cidx_ff;
   logic [IDX_W-1:0]            rd_idx_ff;
   logic [pcrq_pkg::ID_W-1:0]   id_ff;
   logic [SZ_W-1:0]             size_ff;

   // queue state
   logic [NUM_CLIENTS-1:0]      valid_ff, valid_in;
   logic [SLOT_W-1:0]           head_ff, head_in;
   logic [SLOT_W-1:0]           tail_ff, tail_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [pcrq_pkg::QBYTES_W-1:0] bytes_ff, bytes_in;
   logic [pcrq_pkg::TOTAL_W-1:0]  added_ff, added_in;
   logic [pcrq_pkg::TOTAL_W-1:0]  removed_ff, removed_in;

   // outcome of the evaluation cycle
   logic pend_ok_ff, pend_removed_ff, pend_pop_ff;

   // result register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_ok_ff;
   logic                              rsp_removed_ff;
   logic [pcrq_pkg::CLIENT_W-1:0]     rsp_client_ff;
   logic [pcrq_pkg::ID_W-1:0]         rsp_id_ff;
   logic [pcrq_pkg::SIZE_PORT_W-1:0]  rsp_size_ff;
   logic [pcrq_pkg::QCOUNT_W-1:0]     rsp_count_ff;
   logic [pcrq_pkg::QBYTES_W-1:0]     rsp_bytes_ff;
   logic [pcrq_pkg::TOTAL_W-1:0]      rsp_added_ff;
   logic [pcrq_pkg::TOTAL_W-1:0]      rsp_total_rem_ff;

   // request-side decode
   logic             req_cok;
   logic [IDX_W-1:0] req_cidx;
   logic [IDX_W-1:0] rd_addr;
   logic             head_none;
   logic             tail_none;

   // memory ports
   logic [DATA_W-1:0]         data_rd;
   logic [pcrq_pkg::ID_W-1:0] rd_id;
   logic [SZ_W-1:0]           rd_size;
   logic [SLOT_W-1:0]         next_rd, prev_rd;
   logic                      next_we, prev_we;
   logic [IDX_W-1:0]          next_wa, prev_wa;
   logic [SLOT_W-1:0]         next_wd, prev_wd;

   // evaluation
   logic              slot_vld, id_newer, tgt_is_head, tgt_is_tail;
   logic [SLOT_W-1:0] nb_prev, nb_next;
   logic              dec_ok, dec_removed, dec_unlink, dec_link, dec_pop, dec_clear;

   assign head_none = head_ff >= NONE_SLOT;
   assign tail_none = tail_ff >= NONE_SLOT;
   assign req_cok   = 32'(req_client) < NUM_CLIENTS;
   assign req_cidx  = req_cok ? IDX_W'(req_client) : '0;

   // pop reads the head slot, every other mode the addressed client's slot
   always_comb begin
      if (req_mode == pcrq_pkg::MODE_POP) begin
         rd_addr = head_none ? '0 : IDX_W'(head_ff);
      end else begin
         rd_addr = req_cidx;
      end
   end

   assign rd_id   = data_rd[DATA_W-1:SZ_W];
   assign rd_size = data_rd[SZ_W-1:0];

   assign slot_vld    = valid_ff[rd_idx_ff];
   assign id_newer    = id_ff > rd_id;
   assign tgt_is_head = SLOT_W'(rd_idx_ff) == head_ff;
   assign tgt_is_tail = SLOT_W'(rd_idx_ff) == tail_ff;
   // head has no predecessor and tail no successor, whatever the stored pointer says
   assign nb_prev = tgt_is_head ? NONE_SLOT : prev_rd;
   assign nb_next = tgt_is_tail ? NONE_SLOT : next_rd;

   always_comb begin
      dec_ok      = 1'b0;
      dec_removed = 1'b0;
      dec_unlink  = 1'b0;
      dec_link    = 1'b0;
      dec_pop     = 1'b0;
      dec_clear   = 1'b0;
      case (mode_ff)
         pcrq_pkg::MODE_PROBE: begin
            dec_ok = cok_ff && (!slot_vld || id_newer);
         end
         pcrq_pkg::MODE_APPEND: begin
            if (cok_ff) begin
               if (!slot_vld) begin
                  dec_ok   = 1'b1;
                  dec_link = 1'b1;
               end else if (id_newer) begin
                  dec_ok      = 1'b1;
                  dec_link    = 1'b1;
                  dec_unlink  = 1'b1;
                  dec_removed = 1'b1;
               end
            end
         end
         pcrq_pkg::MODE_APPEND_EMPTY: begin
            if (cok_ff && !slot_vld) begin
               dec_ok   = 1'b1;
               dec_link = 1'b1;
            end
         end
         pcrq_pkg::MODE_POP: begin
            if (!head_none && slot_vld) begin
               dec_ok      = 1'b1;
               dec_pop     = 1'b1;
               dec_unlink  = 1'b1;
               dec_removed = 1'b1;
            end
         end
         pcrq_pkg::MODE_REMOVE: begin
            if (cok_ff && slot_vld && rd_id <= id_ff) begin
               dec_ok      = tgt_is_head;
               dec_unlink  = 1'b1;
               dec_removed = 1'b1;
            end
         end
         pcrq_pkg::MODE_CLEAR: begin
            dec_clear   = 1'b1;
            dec_removed = cnt_ff != '0;
         end
         default: begin
         end
      endcase
   end

   assign sts.need_link = dec_link;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   // pointer memory writes: unlink patches the neighbours, link appends at the tail
   always_comb begin
      next_we = 1'b0;
      next_wa = IDX_W'(nb_prev);
      next_wd = nb_next;
      prev_we = 1'b0;
      prev_wa = IDX_W'(nb_next);
      prev_wd = nb_prev;
      if (cmd.eval && dec_unlink) begin
         next_we = !tgt_is_head;
         prev_we = !tgt_is_tail;
      end else if (cmd.link) begin
         next_we = !tail_none;
         next_wa = IDX_W'(tail_ff);
         next_wd = SLOT_W'(cidx_ff);
         prev_we = 1'b1;
         prev_wa = cidx_ff;
         prev_wd = tail_ff;
      end
   end

   always_comb begin
      valid_in   = valid_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      cnt_in     = cnt_ff;
      bytes_in   = bytes_ff;
      added_in   = added_ff;
      removed_in = removed_ff;
      if (cmd.eval && dec_clear) begin
         valid_in   = '0;
         head_in    = NONE_SLOT;
         tail_in    = NONE_SLOT;
         cnt_in     = '0;
         bytes_in   = '0;
         removed_in = removed_ff + pcrq_pkg::TOTAL_W'(cnt_ff);
      end else if (cmd.eval && dec_unlink) begin
         valid_in[rd_idx_ff] = 1'b0;
         cnt_in     = cnt_ff - 1'b1;
         bytes_in   = bytes_ff - pcrq_pkg::QBYTES_W'(rd_size);
         removed_in = removed_ff + 1'b1;
         if (tgt_is_head) begin
            head_in = nb_next;
         end
         if (tgt_is_tail) begin
            tail_in = nb_prev;
         end
      end else if (cmd.link) begin
         valid_in[cidx_ff] = 1'b1;
         cnt_in   = cnt_ff + 1'b1;
         bytes_in = bytes_ff + pcrq_pkg::QBYTES_W'(size_ff);
         added_in = added_ff + 1'b1;
         if (tail_none) begin
            head_in = SLOT_W'(cidx_ff);
         end
         tail_in = SLOT_W'(cidx_ff);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         head_ff      <= NONE_SLOT;
         tail_ff      <= NONE_SLOT;
         cnt_ff       <= '0;
         bytes_ff     <= '0;
         added_ff     <= '0;
         removed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
         bytes_ff     <= bytes_in;
         added_ff     <= added_in;
         removed_ff   <= removed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff   <= req_mode;
         cok_ff    <= req_cok;
         cidx_ff   <= req_cidx;
         rd_idx_ff <= rd_addr;
         id_ff     <= req_request_id;
         size_ff   <= req_request_size[SZ_W-1:0];
      end
      if (cmd.eval) begin
         pend_ok_ff      <= dec_ok;
         pend_removed_ff <= dec_removed;
         pend_pop_ff     <= dec_pop;
      end
      // slot read data stays put until the next request is taken
      if (cmd.emit) begin
         rsp_ok_ff        <= pend_ok_ff;
         rsp_removed_ff   <= pend_removed_ff;
         rsp_client_ff    <= pend_pop_ff ? pcrq_pkg::CLIENT_W'(rd_idx_ff) : '0;
         rsp_id_ff        <= pend_pop_ff ? rd_id : '0;
         rsp_size_ff      <= pend_pop_ff ? pcrq_pkg::SIZE_PORT_W'(rd_size) : '0;
         rsp_count_ff     <= pcrq_pkg::QCOUNT_W'(cnt_ff);
         rsp_bytes_ff     <= bytes_ff;
         rsp_added_ff     <= added_ff;
         rsp_total_rem_ff <= removed_ff;
      end
   end

   pcrq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (NUM_CLIENTS)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (cmd.link),
      .wr_addr (cidx_ff),
      .wr_data ({id_ff, size_ff}),
      .rd_en   (cmd.accept),
      .rd_addr (rd_addr),
      .rd_data (data_rd)
   );

   pcrq_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (NUM_CLIENTS)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_wa),
      .wr_data (next_wd),
      .rd_en   (cmd.accept),
      .rd_addr (rd_addr),
      .rd_data (next_rd)
   );

   pcrq_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (NUM_CLIENTS)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_en   (cmd.accept),
      .rd_addr (rd_addr),
      .rd_data (prev_rd)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_removed_any    = rsp_removed_ff;
   assign rsp_out_client     = rsp_client_ff;
   assign rsp_out_request_id = rsp_id_ff;
   assign rsp_out_size       = rsp_size_ff;
   assign rsp_queue_count    = rsp_count_ff;
   assign rsp_queue_bytes    = rsp_bytes_ff;
   assign rsp_total_added    = rsp_added_ff;
   assign rsp_total_removed  = rsp_total_rem_ff;

endmodule

[dv/tb_per_client_request_queue_core.sv]
// self-checking testbench of per_client_request_queue_core: directed table then random traffic
// predicts each result with its own linked-list model of the queue and compares field by field
// depends on pcrq_pkg and the per_client_request_queue_core rtl

module tb_per_client_request_queue_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int                          NUM_SLOTS       = 64;
   localparam logic [6:0]                  NONE_SLOT       = 7'd64;
   localparam logic [pcrq_pkg::ID_W-1:0]   ID_MAX          = {pcrq_pkg::ID_W{1'b1}};
   localparam logic [pcrq_pkg::MODE_W-1:0] MODE_RSVD6      = 3'd6;
   localparam logic [pcrq_pkg::MODE_W-1:0] MODE_RSVD7      = 3'd7;
   localparam int                          ITEMS_PER_PHASE = 420;
   localparam int                          LONG_HOLD       = 120;

   typedef struct packed {
      logic                             ok;
      logic                             removed_any;
      logic [pcrq_pkg::CLIENT_W-1:0]    client;
      logic [pcrq_pkg::ID_W-1:0]        rid;
      logic [pcrq_pkg::SIZE_PORT_W-1:0] rsize;
      logic [pcrq_pkg::QCOUNT_W-1:0]    count;
      logic [pcrq_pkg::QBYTES_W-1:0]    bytes;
      logic [pcrq_pkg::TOTAL_W-1:0]     added;
      logic [pcrq_pkg::TOTAL_W-1:0]     removed;
   } queue_result_type;

   typedef struct packed {
      logic [pcrq_pkg::MODE_W-1:0]      mode;
      logic [pcrq_pkg::CLIENT_W-1:0]    client;
      logic [pcrq_pkg::ID_W-1:0]        rid;
      logic [pcrq_pkg::SIZE_PORT_W-1:0] rsize;
      logic                             typed;
      queue_result_type                 want;
   } stim_row_type;

   localparam queue_result_type NO_TYPED = '0;
   localparam int DIR_ROWS = 25;

   // expected values are typed in for the opening rows only
   localparam stim_row_type DIR_TABLE [0:DIR_ROWS-1] = '{
      '{pcrq_pkg::MODE_PROBE, 6'd0, 63'd0, 16'd0, 1'b1,
        '{1'b1, 1'b0, 6'd0, 63'd0, 16'd0, 7'd0, 22'd0, 32'd0, 32'd0}},
      '{pcrq_pkg::MODE_POP, 6'd0, 63'd0, 16'd0, 1'b1,
        '{1'b0, 1'b0, 6'd0, 63'd0, 16'd0, 7'd0, 22'd0, 32'd0, 32'd0}},
      '{pcrq_pkg::MODE_REMOVE, 6'd5, ID_MAX, 16'd0, 1'b1,
        '{1'b0, 1'b0, 6'd0, 63'd0, 16'd0, 7'd0, 22'd0, 32'd0, 32'd0}},
      '{pcrq_pkg::MODE_CLEAR, 6'd0, 63'd0, 16'd0, 1'b1,
        '{1'b0, 1'b0, 6'd0, 63'd0, 16'd0, 7'd0, 22'd0, 32'd0, 32'd0}},
      '{pcrq_pkg::MODE_APPEND, 6'd63, ID_MAX, 16'hFFFF, 1'b1,
        '{1'b1, 1'b0, 6'd0, 63'd0, 16'd0, 7'd1, 22'd65535, 32'd1, 32'd0}},
      '{pcrq_pkg::MODE_APPEND, 6'd63, ID_MAX, 16'd1, 1'b1,
        '{1'b0, 1'b0, 6'd0, 63'd0, 16'd0, 7'd1, 22'd65535, 32'd1, 32'd0}},
      '{pcrq_pkg::MODE_APPEND_EMPTY, 6'd0, 63'd0, 16'd0, 1'b1,
        '{1'b1, 1'b0, 6'd0, 63'd0, 16'd0, 7'd2, 22'd65535, 32'd2, 32'd0}},
      '{pcrq_pkg::MODE_APPEND_EMPTY, 6'd0, 63'd7, 16'd9, 1'b1,
        '{1'b0, 1'b0, 6'd0, 63'd0, 16'd0, 7'd2, 22'd65535, 32'd2, 32'd0}},
      '{pcrq_pkg::MODE_PROBE, 6'd63, ID_MAX, 16'd0, 1'b1,
        '{1'b0, 1'b0, 6'd0, 63'd0, 16'd0, 7'd2, 22'd65535, 32'd2, 32'd0}},
      '{pcrq_pkg::MODE_APPEND, 6'd0, 63'd5, 16'd1, 1'b1,
        '{1'b1, 1'b1, 6'd0, 63'd0, 16'd0, 7'd2, 22'd65536, 32'd3, 32'd1}},
      '{pcrq_pkg::MODE_POP, 6'd0, 63'd0, 16'd0, 1'b1,
        '{1'b1, 1'b1, 6'd63, ID_MAX, 16'hFFFF, 7'd1, 22'd1, 32'd3, 32'd2}},
      '{pcrq_pkg::MODE_APPEND, 6'd1, 63'd100, 16'h5555, 1'b0, NO_TYPED},
      '{pcrq_pkg::MODE_APPEND, 6'd2, 63'h2AAA_AAAA_AAAA_AAAA, 16'hAAAA, 1'b0, NO_TYPED},
      '{pcrq_pkg::MODE_APPEND_EMPTY, 6'd42, 63'h5555_5555_5555_5555, 16'h1234, 1'b0,
        NO_TYPED},
      '{pcrq_pkg::MODE_REMOVE, 6'd2, 63'd0, 16'd0, 1'b0, NO_TYPED},
      '{pcrq_pkg::MODE_REMOVE, 6'd1, ID_MAX, 16'd0, 1'b0, NO_TYPED},
      '{pcrq_pkg::MODE_REMOVE, 6'd0, 63'd5, 16'd0, 1'b0, NO_TYPED},
      '{pcrq_pkg::MODE_REMOVE, 6'd42, 63'h5555_5555_5555_5555, 16'd0, 1'b0, NO_TYPED},
      '{MODE_RSVD6, 6'd3, 63'h1234_5678_9ABC_DEF0, 16'hFFFF, 1'b0, NO_TYPED},
      '{MODE_RSVD7, 6'd63, ID_MAX, 16'hFFFF, 1'b0, NO_TYPED},
      '{pcrq_pkg::MODE_APPEND, 6'd3, 63'd1, 16'd2, 1'b0, NO_TYPED},
      '{pcrq_pkg::MODE_CLEAR, 6'd0, 63'd0, 16'd0, 1'b0, NO_TYPED},
      '{pcrq_pkg::MODE_POP, 6'd0, 63'd0, 16'd0, 1'b0, NO_TYPED},
      '{pcrq_pkg::MODE_PROBE, 6'd2, 63'd0, 16'd0, 1'b0, NO_TYPED},
      '{pcrq_pkg::MODE_APPEND, 6'd0, 63'd0, 16'h8001, 1'b0, NO_TYPED}
   };

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [pcrq_pkg::MODE_W-1:0]      req_mode = '0;
   logic [pcrq_pkg::CLIENT_W-1:0]    req_client = '0;
   logic [pcrq_pkg::ID_W-1:0]        req_request_id = '0;
   logic [pcrq_pkg::SIZE_PORT_W-1:0] req_request_size = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b1;
   logic                             rsp_ok;
   logic                             rsp_removed_any;
   logic [pcrq_pkg::CLIENT_W-1:0]    rsp_out_client;
   logic [pcrq_pkg::ID_W-1:0]        rsp_out_request_id;
   logic [pcrq_pkg::SIZE_PORT_W-1:0] rsp_out_size;
   logic [pcrq_pkg::QCOUNT_W-1:0]    rsp_queue_count;
   logic [pcrq_pkg::QBYTES_W-1:0]    rsp_queue_bytes;
   logic [pcrq_pkg::TOTAL_W-1:0]     rsp_total_added;
   logic [pcrq_pkg::TOTAL_W-1:0]     rsp_total_removed;

   // typed expectation travels with the request it belongs to
   logic                             req_typed = 1'b0;
   queue_result_type                 req_want = '0;

   // predictor copy of the queue
   bit                               occ [NUM_SLOTS];
   logic [pcrq_pkg::ID_W-1:0]        occ_id [NUM_SLOTS];
   logic [pcrq_pkg::SIZE_PORT_W-1:0] occ_size [NUM_SLOTS];
   logic [6:0]                       link_prev [NUM_SLOTS];
   logic [6:0]                       link_next [NUM_SLOTS];
   logic [6:0]                       first_slot = NONE_SLOT;
   logic [6:0]                       last_slot = NONE_SLOT;
   logic [pcrq_pkg::QCOUNT_W-1:0]    n_entries = '0;
   logic [pcrq_pkg::QBYTES_W-1:0]    n_bytes = '0;
   logic [pcrq_pkg::TOTAL_W-1:0]     n_added = '0;
   logic [pcrq_pkg::TOTAL_W-1:0]     n_removed = '0;

   queue_result_type                 pending_results [$];
   logic [pcrq_pkg::ID_W-1:0]        gen_id [NUM_SLOTS];

   int sender_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_asks = 0;
   int hold_served = 0;
   int hold_left = 0;
   int mismatches = 0;
   int results_checked = 0;
   int sent_items = 0;
   int ignored_items = 0;
   int peak_depth = 0;

   per_client_request_queue_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_client         (req_client),
      .req_request_id     (req_request_id),
      .req_request_size   (req_request_size),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_ok             (rsp_ok),
      .rsp_removed_any    (rsp_removed_any),
      .rsp_out_client     (rsp_out_client),
      .rsp_out_request_id (rsp_out_request_id),
      .rsp_out_size       (rsp_out_size),
      .rsp_queue_count    (rsp_queue_count),
      .rsp_queue_bytes    (rsp_queue_bytes),
      .rsp_total_added    (rsp_total_added),
      .rsp_total_removed  (rsp_total_removed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(5_000_000);
      $display("Verification failed");
      $finish;
   end

   function automatic void unlink_slot(logic [5:0] c);
      logic [6:0] p;
      logic [6:0] n;
      p = link_prev[c];
      n = link_next[c];
      n_entries = n_entries - 7'd1;
      n_removed = n_removed + 32'd1;
      n_bytes   = n_bytes - {6'd0, occ_size[c]};
      occ[c]    = 1'b0;
      if (p >= NONE_SLOT) begin
         first_slot = n;
      end else begin
         link_next[p[5:0]] = n;
      end
      if (n >= NONE_SLOT) begin
         last_slot = p;
      end else begin
         link_prev[n[5:0]] = p;
      end
   endfunction

   function automatic void link_tail(logic [5:0] c, logic [pcrq_pkg::ID_W-1:0] rid,
                                     logic [pcrq_pkg::SIZE_PORT_W-1:0] rsize);
      occ[c]      = 1'b1;
      occ_id[c]   = rid;
      occ_size[c] = rsize;
      n_bytes     = n_bytes + {6'd0, rsize};
      n_entries   = n_entries + 7'd1;
      n_added     = n_added + 32'd1;
      link_next[c] = NONE_SLOT;
      if (first_slot >= NONE_SLOT || last_slot >= NONE_SLOT) begin
         link_prev[c] = NONE_SLOT;
         first_slot   = {1'b0, c};
      end else begin
         link_next[last_slot[5:0]] = {1'b0, c};
         link_prev[c] = last_slot;
      end
      last_slot = {1'b0, c};
   endfunction

   function automatic queue_result_type predict_queue_op(
         logic [pcrq_pkg::MODE_W-1:0] mode,
         logic [pcrq_pkg::CLIENT_W-1:0] c,
         logic [pcrq_pkg::ID_W-1:0] rid,
         logic [pcrq_pkg::SIZE_PORT_W-1:0] rsize);
      queue_result_type r;
      logic [5:0] h;
      r = '0;
      case (mode)
         pcrq_pkg::MODE_PROBE: begin
            r.ok = !occ[c] || rid > occ_id[c];
         end
         pcrq_pkg::MODE_APPEND: begin
            // a newer id replaces the old entry and moves it to the tail
            if (occ[c]) begin
               if (rid > occ_id[c]) begin
                  unlink_slot(c);
                  r.removed_any = 1'b1;
                  r.ok = 1'b1;
               end
            end else begin
               r.ok = 1'b1;
            end
            if (r.ok) link_tail(c, rid, rsize);
         end
         pcrq_pkg::MODE_APPEND_EMPTY: begin
            if (!occ[c]) begin
               link_tail(c, rid, rsize);
               r.ok = 1'b1;
            end
         end
         pcrq_pkg::MODE_POP: begin
            if (first_slot < NONE_SLOT && occ[first_slot[5:0]]) begin
               h = first_slot[5:0];
               r.client = h;
               r.rid    = occ_id[h];
               r.rsize  = occ_size[h];
               unlink_slot(h);
               r.ok = 1'b1;
               r.removed_any = 1'b1;
            end
         end
         pcrq_pkg::MODE_REMOVE: begin
            if (occ[c] && occ_id[c] <= rid) begin
               r.ok = link_prev[c] >= NONE_SLOT;
               unlink_slot(c);
               r.removed_any = 1'b1;
            end
         end
         pcrq_pkg::MODE_CLEAR: begin
            r.removed_any = n_entries != '0;
            n_removed = n_removed + {25'd0, n_entries};
            for (int i = 0; i < NUM_SLOTS; i++) begin
               occ[i]       = 1'b0;
               link_prev[i] = NONE_SLOT;
               link_next[i] = NONE_SLOT;
            end
            first_slot = NONE_SLOT;
            last_slot  = NONE_SLOT;
            n_entries  = '0;
            n_bytes    = '0;
         end
         default: ;
      endcase
      r.count   = n_entries;
      r.bytes   = n_bytes;
      r.added   = n_added;
      r.removed = n_removed;
      return r;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : monitor_blk
      queue_result_type predicted;
      queue_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predicted = predict_queue_op(req_mode, req_client, req_request_id,
                                         req_request_size);
            pending_results.push_back(req_typed ? req_want : predicted);
            if (int'(predicted.count) > peak_depth) peak_depth = int'(predicted.count);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result with no request outstanding, expected none, got count %0d",
                        $time, rsp_queue_count);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               results_checked++;
               check_field("ok", 64'(want.ok), 64'(rsp_ok));
               check_field("removed_any", 64'(want.removed_any), 64'(rsp_removed_any));
               check_field("out_client", 64'(want.client), 64'(rsp_out_client));
               check_field("out_request_id", 64'(want.rid), 64'(rsp_out_request_id));
               check_field("out_size", 64'(want.rsize), 64'(rsp_out_size));
               check_field("queue_count", 64'(want.count), 64'(rsp_queue_count));
               check_field("queue_bytes", 64'(want.bytes), 64'(rsp_queue_bytes));
               check_field("total_added", 64'(want.added), 64'(rsp_total_added));
               check_field("total_removed", 64'(want.removed), 64'(rsp_total_removed));
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold-off whenever one is asked for
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asks) begin
         hold_served <= hold_served + 1;
         hold_left   <= LONG_HOLD;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_request(logic [pcrq_pkg::MODE_W-1:0] mode,
                               logic [pcrq_pkg::CLIENT_W-1:0] c,
                               logic [pcrq_pkg::ID_W-1:0] rid,
                               logic [pcrq_pkg::SIZE_PORT_W-1:0] rsize,
                               logic typed, queue_result_type want);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_client       <= c;
      req_request_id   <= rid;
      req_request_size <= rsize;
      req_typed        <= typed;
      req_want         <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [pcrq_pkg::ID_W-1:0] random_id();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[pcrq_pkg::ID_W-1:0];
   endfunction

   // step a client's id forward, pulling it back down when it nears the top
   function automatic logic [pcrq_pkg::ID_W-1:0] newer_id(logic [5:0] c);
      if (gen_id[c] > ID_MAX - 63'd100000) gen_id[c] = random_id() >> 1;
      gen_id[c] = gen_id[c] + 63'($urandom_range(1000, 1));
      return gen_id[c];
   endfunction

   task automatic send_random_item(output bit ignored);
      int unsigned pick;
      logic [5:0] c;
      logic [pcrq_pkg::MODE_W-1:0] m;
      logic [pcrq_pkg::ID_W-1:0] rid;
      logic [pcrq_pkg::SIZE_PORT_W-1:0] sz;
      pick = $urandom_range(99);
      c = 6'($urandom_range(63));
      rid = gen_id[c];
      case ($urandom_range(9))
         0, 1:    sz = 16'hFFFF;
         2:       sz = 16'd0;
         default: sz = 16'($urandom);
      endcase
      ignored = 1'b0;
      if (pick < 38) begin
         m = ($urandom_range(9) < 7) ? pcrq_pkg::MODE_APPEND : pcrq_pkg::MODE_APPEND_EMPTY;
         case ($urandom_range(19))
            0, 1: rid = gen_id[c];
            2:    rid = gen_id[c] - 63'd1;
            3: begin
               rid = random_id();
               if (rid > gen_id[c]) gen_id[c] = rid;
            end
            default: rid = newer_id(c);
         endcase
      end else if (pick < 58) begin
         m = pcrq_pkg::MODE_POP;
         rid = random_id();
      end else if (pick < 72) begin
         m = pcrq_pkg::MODE_REMOVE;
         case ($urandom_range(4))
            0:       rid = gen_id[c] - 63'd1;
            1:       rid = random_id();
            default: rid = gen_id[c];
         endcase
      end else if (pick < 84) begin
         m = pcrq_pkg::MODE_PROBE;
         rid = gen_id[c] + 63'($urandom_range(2)) - 63'd1;
      end else if (pick < 86) begin
         m = pcrq_pkg::MODE_CLEAR;
      end else if (pick < 93) begin
         m = $urandom_range(1) ? MODE_RSVD7 : MODE_RSVD6;
         rid = random_id();
         ignored = 1'b1;
      end else begin
         m = 3'($urandom_range(7));
         rid = random_id();
         ignored = (m >= MODE_RSVD6);
      end
      send_request(m, c, rid, sz, 1'b0, NO_TYPED);
   endtask

   initial begin
      int phase_items;
      bit ignored;
      for (int i = 0; i < NUM_SLOTS; i++) gen_id[i] = random_id() >> 1;
      do @(posedge clock); while (reset);

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_request(DIR_TABLE[i].mode, DIR_TABLE[i].client, DIR_TABLE[i].rid,
                      DIR_TABLE[i].rsize, DIR_TABLE[i].typed, DIR_TABLE[i].want);
         sent_items++;
      end
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  rsp_stall_pct <= 0;  end
            1: begin sender_idle_pct = 59; rsp_stall_pct <= 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct <= 59; end
            default: begin sender_idle_pct = 21; rsp_stall_pct <= 21; end
         endcase
         phase_items = 0;
         // fill every slot with a full-size request to reach the count and byte maxima
         for (int i = 0; i < NUM_SLOTS; i++) begin
            send_request(pcrq_pkg::MODE_APPEND, 6'(i), newer_id(6'(i)), 16'hFFFF, 1'b0,
                         NO_TYPED);
            phase_items++;
         end
         while (phase_items < ITEMS_PER_PHASE) begin
            if (phase_items == 200 && (phase == 0 || phase == 2)) hold_asks <= hold_asks + 1;
            send_random_item(ignored);
            if (ignored) ignored_items++;
            else phase_items++;
         end
         sent_items += phase_items;
         wait_drained();
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Run covered %0d requests plus %0d in unused modes, %0d results checked.",
               sent_items, ignored_items, results_checked);
      $display("Peak queue depth %0d over four idle and stall phases with long hold-offs.",
               peak_depth);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
